// ----- rtl/core/sgtu_pkg.sv -----
// Shared types, constants and fp32 helpers for the SiLU gated product block.
// No dependencies; sgtu_fp_add, sgtu_fp_mul and silu_gate_times_up_lut import this package.
`default_nettype none

package sgtu_pkg;

  localparam int TableEntries = 128;
  localparam int IdxW         = 7;

  localparam logic [31:0] Fp32DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] Fp32QuietBit   = 32'h0040_0000;
  localparam logic [7:0]  Fp32ExpMax     = 8'hFF;

  // Enables of the two register stages inside an arithmetic unit.
  typedef struct packed {
    logic a;
    logic b;
  } unit_en_t;

  function automatic logic fp32_is_nan(input logic [31:0] x);
    return (x[30:23] == Fp32ExpMax) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic fp32_is_inf(input logic [31:0] x);
    return (x[30:23] == Fp32ExpMax) && (x[22:0] == 23'd0);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sgtu_ram.sv -----
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`default_nettype none

module sgtu_ram #(
  parameter int Width = 16,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr0_i,
  input  wire logic [$clog2(Depth)-1:0] raddr1_i,
  output logic      [Width-1:0]         rdata0_o,
  output logic      [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sgtu_fp_add.sv -----
// Two-stage IEEE binary32 adder, round to nearest even, subnormals kept.
// Depends on sgtu_pkg for the stage enable type and NaN helpers.
`default_nettype none

module sgtu_fp_add
  import sgtu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire unit_en_t    en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] sum_o
);

  function automatic logic [4:0] lzc27(input logic [26:0] x);
    logic [4:0] n;
    logic       found;
    n     = 5'd27;
    found = 1'b0;
    for (int k = 26; k >= 0; k--) begin
      if (!found && x[k]) begin
        n     = 5'(26 - k);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Stage A: order, align, add.
  logic        swap;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, diff;
  logic [23:0] mb, ms;
  logic [4:0]  dcl;
  logic [53:0] wide;
  logic [26:0] al;
  logic [27:0] sum;
  logic        spec;
  logic [31:0] spec_val;

  logic        sign_q, zsign_q, spec_q;
  logic [7:0]  e_q;
  logic [27:0] sum_q;
  logic [31:0] spec_val_q;

  always_comb begin
    swap = b_i[30:0] > a_i[30:0];
    big  = swap ? b_i : a_i;
    sml  = swap ? a_i : b_i;
    eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb   = {big[30:23] != 8'd0, big[22:0]};
    ms   = {sml[30:23] != 8'd0, sml[22:0]};
    diff = eb - es;
    dcl  = (diff >= 8'd27) ? 5'd27 : diff[4:0];
    wide = {ms, 3'b000, 27'd0} >> dcl;
    al   = {wide[53:28], wide[27] | (|wide[26:0])};
    if (a_i[31] ^ b_i[31]) begin
      sum = {1'b0, mb, 3'b000} - {1'b0, al};
    end else begin
      sum = {1'b0, mb, 3'b000} + {1'b0, al};
    end
    spec = fp32_is_nan(a_i) | fp32_is_nan(b_i) | fp32_is_inf(a_i) | fp32_is_inf(b_i);
    if (fp32_is_nan(a_i)) begin
      spec_val = a_i | Fp32QuietBit;
    end else if (fp32_is_nan(b_i)) begin
      spec_val = b_i | Fp32QuietBit;
    end else if (fp32_is_inf(a_i) && fp32_is_inf(b_i) && (a_i[31] != b_i[31])) begin
      spec_val = Fp32DefaultNan;
    end else if (fp32_is_inf(a_i)) begin
      spec_val = a_i;
    end else begin
      spec_val = b_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      sign_q     <= big[31];
      zsign_q    <= a_i[31] & b_i[31];
      e_q        <= eb;
      sum_q      <= sum;
      spec_q     <= spec;
      spec_val_q <= spec_val;
    end
  end

  // Stage B: normalize and round.
  logic [4:0]  lz;
  logic [7:0]  lim, sh;
  logic [26:0] n;
  logic [8:0]  e9, ee;
  logic        inc, hidden;
  logic [24:0] mr;
  logic [31:0] res;

  always_comb begin
    lz  = lzc27(sum_q[26:0]);
    lim = e_q - 8'd1;
    sh  = ({3'b000, lz} < lim) ? {3'b000, lz} : lim;
    if (sum_q[27]) begin
      n  = {sum_q[27:2], sum_q[1] | sum_q[0]};
      e9 = {1'b0, e_q} + 9'd1;
    end else begin
      n  = sum_q[26:0] << sh;
      e9 = {1'b0, e_q} - {1'b0, sh};
    end
    inc    = n[2] & (n[1] | n[0] | n[3]);
    mr     = {1'b0, n[26:3]} + {24'd0, inc};
    ee     = e9 + {8'd0, mr[24]};
    hidden = mr[24] | mr[23];
    if (spec_q) begin
      res = spec_val_q;
    end else if (sum_q == 28'd0) begin
      res = {zsign_q, 31'd0};
    end else if (ee >= 9'd255) begin
      res = {sign_q, Fp32ExpMax, 23'd0};
    end else begin
      res = {sign_q, hidden ? ee[7:0] : 8'd0, mr[24] ? 23'd0 : mr[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      sum_o <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sgtu_fp_mul.sv -----
// Two-stage IEEE binary32 multiplier, round to nearest even, subnormals kept.
// Depends on sgtu_pkg for the stage enable type and NaN helpers.
`default_nettype none

module sgtu_fp_mul
  import sgtu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire unit_en_t    en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] prod_o
);

  function automatic logic [5:0] lzc48(input logic [47:0] x);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int k = 47; k >= 0; k--) begin
      if (!found && x[k]) begin
        n     = 6'(47 - k);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Stage A: significand product and exponent sum.
  logic [23:0] ma, mb;
  logic [8:0]  esum;
  logic        spec, a_zero, b_zero;
  logic [31:0] spec_val;

  logic        sign_q, spec_q;
  logic [8:0]  esum_q;
  logic [47:0] p_q;
  logic [31:0] spec_val_q;

  always_comb begin
    ma     = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb     = {b_i[30:23] != 8'd0, b_i[22:0]};
    esum   = {1'b0, (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23]}
           + {1'b0, (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23]};
    a_zero = a_i[30:0] == 31'd0;
    b_zero = b_i[30:0] == 31'd0;
    spec   = fp32_is_nan(a_i) | fp32_is_nan(b_i) | fp32_is_inf(a_i) | fp32_is_inf(b_i);
    if (fp32_is_nan(a_i)) begin
      spec_val = a_i | Fp32QuietBit;
    end else if (fp32_is_nan(b_i)) begin
      spec_val = b_i | Fp32QuietBit;
    end else if ((fp32_is_inf(a_i) && b_zero) || (fp32_is_inf(b_i) && a_zero)) begin
      spec_val = Fp32DefaultNan;
    end else begin
      spec_val = {a_i[31] ^ b_i[31], Fp32ExpMax, 23'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      sign_q     <= a_i[31] ^ b_i[31];
      esum_q     <= esum;
      p_q        <= ma * mb;
      spec_q     <= spec;
      spec_val_q <= spec_val;
    end
  end

  // Stage B: normalize, handle the subnormal range, round.
  logic [5:0]         lz;
  logic signed [10:0] en_s, base;
  logic [10:0]        rs;
  logic [5:0]         rsc;
  logic [95:0]        wide;
  logic [47:0]        n;
  logic [9:0]         e10, ee;
  logic               inc, hidden;
  logic [24:0]        mr;
  logic [31:0]        res;

  always_comb begin
    lz   = lzc48(p_q);
    en_s = $signed({2'b00, esum_q}) - 11'sd126 - $signed({5'd0, lz});
    base = $signed({2'b00, esum_q}) - 11'sd127;
    rs   = 11'(-base);
    rsc  = (rs > 11'd48) ? 6'd48 : rs[5:0];
    wide = {p_q, 48'd0} >> rsc;
    if (en_s > 11'sd0) begin
      n   = p_q << lz;
      e10 = en_s[9:0];
    end else if (base >= 11'sd0) begin
      n   = p_q << base[5:0];
      e10 = 10'd1;
    end else begin
      n   = {wide[95:49], wide[48] | (|wide[47:0])};
      e10 = 10'd1;
    end
    inc    = n[23] & ((|n[22:0]) | n[24]);
    mr     = {1'b0, n[47:24]} + {24'd0, inc};
    ee     = e10 + {9'd0, mr[24]};
    hidden = mr[24] | mr[23];
    if (spec_q) begin
      res = spec_val_q;
    end else if (p_q == 48'd0) begin
      res = {sign_q, 31'd0};
    end else if (ee >= 10'd255) begin
      res = {sign_q, Fp32ExpMax, 23'd0};
    end else begin
      res = {sign_q, hidden ? ee[7:0] : 8'd0, mr[24] ? 23'd0 : mr[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      prod_o <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/silu_gate_times_up_lut.sv -----
// One transfer per cycle is sustained while the output is not stalled.
// The 12 register stages are: decode, table read, fp16 widen, and four two-stage
// fp32 units (difference, fraction scale, interpolation add, product with up),
// then the bf16 rounding register. Each stage stalls only when full and blocked.
// Reset clears all valid bits; table contents are undefined until written.
`default_nettype none

module silu_gate_times_up_lut
  import sgtu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] gate_bf16, [31:16] up_bf16, [38:32] entry_index, [54:39] entry_value
  input  wire logic [55:0] s_axis_tdata,
  // [0] op
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] product_bf16
  output logic      [15:0] m_axis_tdata
);

  localparam int Stages = 12;
  localparam logic [16:0] QOne = 17'd32768;

  function automatic logic [31:0] half_to_fp32(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  top;
    logic [31:0] r;
    e   = h[14:10];
    m   = h[9:0];
    top = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (m[k]) begin
        top = 4'(k);
      end
    end
    if (e == 5'd0) begin
      if (m == 10'd0) begin
        r = {h[15], 31'd0};
      end else begin
        r = {h[15], 8'd103 + {4'd0, top}, 23'({m, 13'd0} << (4'd10 - top))};
      end
    end else if (e == 5'd31) begin
      r = {h[15], Fp32ExpMax, m, 13'd0};
    end else begin
      r = {h[15], {3'd0, e} + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] frac_to_fp32(input logic [11:0] f);
    logic [3:0]  top;
    logic [31:0] r;
    top = 4'd0;
    for (int k = 0; k < 12; k++) begin
      if (f[k]) begin
        top = 4'(k);
      end
    end
    if (f == 12'd0) begin
      r = 32'd0;
    end else begin
      r = {1'b0, 8'd115 + {4'd0, top}, 23'({f, 11'd0} << (4'd12 - top))};
    end
    return r;
  endfunction

  function automatic logic [15:0] round_bf16(input logic [31:0] w);
    logic [31:0] s;
    s = w + 32'h0000_7FFF + {31'd0, w[16]};
    return fp32_is_nan(w) ? (w[31:16] | 16'h0040) : s[31:16];
  endfunction

  // Stage handshake: a stage loads when it is empty or the next one loads.
  logic [Stages:1] v_q, en, vin;

  always_comb begin
    en[Stages] = !v_q[Stages] || m_axis_tready;
    for (int k = Stages - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  logic op1_q;

  always_comb begin
    vin[1] = s_axis_tvalid;
    vin[2] = v_q[1] && !op1_q;
    for (int k = 3; k <= Stages; k++) begin
      vin[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= Stages; k++) begin
        if (en[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = v_q[Stages];

  // Stage 1: gate to Q12, special cases, table index and fraction.
  logic [15:0]     g;
  logic [7:0]      ge, rsh8;
  logic [7:0]      sig;
  logic [3:0]      rsh;
  logic [16:0]     mag, qp17;
  logic [22:0]     p127;
  logic [18:0]     p;
  logic [IdxW-1:0] ti;
  logic            interp;
  logic [31:0]     yspec;

  always_comb begin
    g    = s_axis_tdata[15:0];
    ge   = g[14:7];
    sig  = {1'b1, g[6:0]};
    rsh8 = 8'd122 - ge;
    rsh  = rsh8[3:0];
    if (ge == Fp32ExpMax) begin
      mag = QOne;
    end else if (ge == 8'd0) begin
      mag = 17'd0;
    end else if (ge >= 8'd130) begin
      mag = QOne;
    end else if (ge >= 8'd122) begin
      mag = {9'd0, sig} << 3'(ge - 8'd122);
    end else if (rsh8 >= 8'd16) begin
      mag = 17'd0;
    end else begin
      mag = ({9'd0, sig} + (17'd1 << (rsh - 4'd1))) >> rsh;
    end
    qp17   = g[15] ? (QOne - mag) : (QOne + mag);
    p127   = {qp17[15:0], 7'd0} - {7'd0, qp17[15:0]};
    p      = p127[22:4];
    ti     = (p[18:12] == 7'(TableEntries - 1)) ? 7'(TableEntries - 2) : p[18:12];
    interp = 1'b0;
    if (ge == Fp32ExpMax && g[6:0] != 7'd0) begin
      yspec = {g, 16'd0};
    end else if (g[14:0] == 15'd0 || (g[15] && mag == QOne)) begin
      yspec = 32'd0;
    end else if (mag == 17'd0) begin
      yspec = (ge >= 8'd2) ? {g[15], ge - 8'd1, g[6:0], 16'd0}
                           : {g[15], 8'd0, ge[0], g[6:0], 15'd0};
    end else if (mag == QOne) begin
      yspec = {g, 16'd0};
    end else begin
      yspec  = 32'd0;
      interp = 1'b1;
    end
  end

  logic [IdxW-1:0] addr1_q;
  logic [15:0]     wval1_q, up1_q;
  logic            interp1_q;
  logic [31:0]     yspec1_q, fr1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      op1_q     <= s_axis_tuser;
      addr1_q   <= s_axis_tuser ? s_axis_tdata[38:32] : ti;
      wval1_q   <= s_axis_tdata[54:39];
      up1_q     <= s_axis_tdata[31:16];
      interp1_q <= interp;
      yspec1_q  <= yspec;
      fr1_q     <= frac_to_fp32(p[11:0]);
    end
  end

  // Stage 2: table write or read of the two neighboring samples.
  logic [15:0] t0, t1;

  sgtu_ram #(
    .Width(16),
    .Depth(TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (en[2] && v_q[1] && op1_q),
    .waddr_i (addr1_q),
    .wdata_i (wval1_q),
    .re_i    (en[2]),
    .raddr0_i(addr1_q),
    .raddr1_i(addr1_q + 7'd1),
    .rdata0_o(t0),
    .rdata1_o(t1)
  );

  logic [15:0] up2_q;
  logic        interp2_q;
  logic [31:0] yspec2_q, fr2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      up2_q     <= up1_q;
      interp2_q <= interp1_q;
      yspec2_q  <= yspec1_q;
      fr2_q     <= fr1_q;
    end
  end

  // Stage 3: widen fp16 samples to fp32.
  logic [31:0] y0_3_q, y1_3_q, yspec3_q, fr3_q;
  logic [15:0] up3_q;
  logic        interp3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      y0_3_q    <= half_to_fp32(t0);
      y1_3_q    <= half_to_fp32(t1);
      up3_q     <= up2_q;
      interp3_q <= interp2_q;
      yspec3_q  <= yspec2_q;
      fr3_q     <= fr2_q;
    end
  end

  // Stages 4-5: d = y1 - y0; a NaN y0 propagates with its own sign.
  logic [31:0] y0_neg, d;

  assign y0_neg = fp32_is_nan(y0_3_q) ? y0_3_q : {~y0_3_q[31], y0_3_q[30:0]};

  sgtu_fp_add u_add_d (
    .clk_i(clk_i),
    .en_i ('{a: en[4], b: en[5]}),
    .a_i  (y1_3_q),
    .b_i  (y0_neg),
    .sum_o(d)
  );

  logic [31:0] y0_4_q, y0_5_q, y0_6_q, y0_7_q;
  logic [31:0] ys4_q, ys5_q, ys6_q, ys7_q, ys8_q, ys9_q;
  logic [31:0] fr4_q, fr5_q;
  logic [15:0] up4_q, up5_q, up6_q, up7_q, up8_q, up9_q;
  logic        ip4_q, ip5_q, ip6_q, ip7_q, ip8_q, ip9_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      y0_4_q <= y0_3_q;
      ys4_q  <= yspec3_q;
      fr4_q  <= fr3_q;
      up4_q  <= up3_q;
      ip4_q  <= interp3_q;
    end
    if (en[5]) begin
      y0_5_q <= y0_4_q;
      ys5_q  <= ys4_q;
      fr5_q  <= fr4_q;
      up5_q  <= up4_q;
      ip5_q  <= ip4_q;
    end
    if (en[6]) begin
      y0_6_q <= y0_5_q;
      ys6_q  <= ys5_q;
      up6_q  <= up5_q;
      ip6_q  <= ip5_q;
    end
    if (en[7]) begin
      y0_7_q <= y0_6_q;
      ys7_q  <= ys6_q;
      up7_q  <= up6_q;
      ip7_q  <= ip6_q;
    end
    if (en[8]) begin
      ys8_q <= ys7_q;
      up8_q <= up7_q;
      ip8_q <= ip7_q;
    end
    if (en[9]) begin
      ys9_q <= ys8_q;
      up9_q <= up8_q;
      ip9_q <= ip8_q;
    end
  end

  // Stages 6-7: t = d * fraction.
  logic [31:0] t;

  sgtu_fp_mul u_mul_t (
    .clk_i (clk_i),
    .en_i  ('{a: en[6], b: en[7]}),
    .a_i   (d),
    .b_i   (fr5_q),
    .prod_o(t)
  );

  // Stages 8-9: interpolated value y0 + t.
  logic [31:0] yint;

  sgtu_fp_add u_add_y (
    .clk_i(clk_i),
    .en_i ('{a: en[8], b: en[9]}),
    .a_i  (y0_7_q),
    .b_i  (t),
    .sum_o(yint)
  );

  // Stages 10-11: y times up.
  logic [31:0] prod;

  sgtu_fp_mul u_mul_up (
    .clk_i (clk_i),
    .en_i  ('{a: en[10], b: en[11]}),
    .a_i   (ip9_q ? yint : ys9_q),
    .b_i   ({up9_q, 16'd0}),
    .prod_o(prod)
  );

  // Stage 12: bf16 rounding into the output register.
  always_ff @(posedge clk_i) begin
    if (en[Stages]) begin
      m_axis_tdata <= round_bf16(prod);
    end
  end

endmodule

`default_nettype wire

// ----- test/silu_gate_times_up_lut_checker.sv -----
// Checker for the SiLU gated product block: it watches both stream channels,
// predicts each product from its own table copy and fp32 arithmetic, and compares.
// Depends on nothing but the ports of silu_gate_times_up_lut.
module silu_gate_times_up_lut_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          errors_o,
  output int          pending_o
);

  localparam logic        OpProduct = 1'b0;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] HalfOne    = 32'h3F00_0000;

  logic [15:0] silu_samples [128];
  logic [15:0] product_q [$];

  function automatic logic is_nan32(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  function automatic logic is_inf32(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 0);
  endfunction

  function automatic real fp32_value(logic [31:0] x);
    real r;
    if (x[30:23] == 0) begin
      r = real'(x[22:0]) * (2.0 ** -149);
      return x[31] ? -r : r;
    end
    return $bitstoreal({x[31], 11'(int'(x[30:23]) - 127 + 1023), x[22:0], 29'd0});
  endfunction

  // Rounds a double to fp32, nearest even, keeping subnormals.
  function automatic logic [31:0] fp32_round(real r);
    logic [63:0] db;
    logic [63:0] mant, q, rem, half;
    int expo, shift;
    db = $realtobits(r);
    if (r == 0.0) return {db[63], 31'd0};
    expo = int'(db[62:52]) - 1023;
    mant = {11'd1, db[51:0]};
    shift = (expo >= -126) ? 29 : 29 + (-126 - expo);
    if (shift > 54) return {db[63], 31'd0};
    q = mant >> shift;
    rem = mant & ((64'd1 << shift) - 1);
    half = 64'd1 << (shift - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (expo < -126) return {db[63], q[30:0]};
    if (q == (64'd1 << 24)) begin
      q = 64'd1 << 23;
      expo++;
    end
    if (expo > 127) return {db[63], 8'hFF, 23'd0};
    return {db[63], 8'(expo + 127), q[22:0]};
  endfunction

  function automatic logic [31:0] fp32_mul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    real r;
    sgn = a[31] ^ b[31];
    if (is_nan32(a)) return a | 32'h0040_0000;
    if (is_nan32(b)) return b | 32'h0040_0000;
    if ((is_inf32(a) && b[30:0] == 0) || (is_inf32(b) && a[30:0] == 0)) return DefaultNan;
    if (is_inf32(a) || is_inf32(b)) return {sgn, 8'hFF, 23'd0};
    r = fp32_value(a) * fp32_value(b);
    if (r == 0.0) return {sgn, 31'd0};
    return fp32_round(r);
  endfunction

  function automatic logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
    real r;
    if (is_nan32(a)) return a | 32'h0040_0000;
    if (is_nan32(b)) return b | 32'h0040_0000;
    if (is_inf32(a) && is_inf32(b) && a[31] != b[31]) return DefaultNan;
    if (is_inf32(a)) return a;
    if (is_inf32(b)) return b;
    r = fp32_value(a) + fp32_value(b);
    if (r == 0.0) return {a[31] & b[31], 31'd0};
    return fp32_round(r);
  endfunction

  function automatic logic [31:0] half_to_fp32(logic [15:0] h);
    int top;
    if (h[14:10] == 0) begin
      if (h[9:0] == 0) return {h[15], 31'd0};
      top = 9;
      while (!h[top]) top--;
      return {h[15], 8'(103 + top), 23'((32'(h[9:0]) << (23 - top)) & 32'h7F_FFFF)};
    end
    if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
  endfunction

  function automatic int gate_to_q12(logic [15:0] h);
    int e, sig, mag, sh, r;
    e = h[14:7];
    sig = 128 + h[6:0];
    if (e == 255) mag = 32768;
    else if (e == 0) mag = 0;
    else begin
      sh = e - 122;
      if (sh >= 8) mag = 32768;
      else if (sh >= 0) mag = sig << sh;
      else begin
        r = -sh;
        mag = (r >= 16) ? 0 : ((sig + (1 << (r - 1))) >> r);
      end
      if (mag > 32768) mag = 32768;
    end
    return h[15] ? -mag : mag;
  endfunction

  function automatic logic [15:0] silu_product(logic [15:0] g, logic [15:0] u);
    logic [31:0] gate, up, y, y0, y1, fr, d, t, prod;
    int q;
    int unsigned p, idx;
    gate = {g, 16'd0};
    up = {u, 16'd0};
    q = gate_to_q12(g);
    if (g[14:7] == 8'hFF && g[6:0] != 0) y = gate;
    else if (g[14:0] == 0 || q <= -32768) y = 32'd0;
    else if (q == 0) y = fp32_mul(gate, HalfOne);
    else if (q >= 32768) y = gate;
    else begin
      p = (unsigned'(q + 32768) * 127) >> 4;
      idx = p >> 12;
      if (idx > 126) idx = 126;
      y0 = half_to_fp32(silu_samples[idx]);
      y1 = half_to_fp32(silu_samples[idx + 1]);
      fr = fp32_round(real'(p & 4095) / 4096.0);
      d = fp32_add(y1, {~y0[31], y0[30:0]});
      t = fp32_mul(d, fr);
      y = fp32_add(y0, t);
    end
    prod = fp32_mul(y, up);
    if (is_nan32(prod)) return prod[31:16] | 16'h0040;
    prod = prod + 32'h7FFF + prod[16];
    return prod[31:16];
  endfunction

  assign pending_o = product_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      errors_o <= 0;
      product_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OpProduct)
          product_q.push_back(silu_product(s_axis_tdata[15:0], s_axis_tdata[31:16]));
        else
          silu_samples[s_axis_tdata[38:32]] = s_axis_tdata[54:39];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (product_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %h", $time, m_axis_tdata);
          errors_o <= errors_o + 1;
        end else if (product_q[0] !== m_axis_tdata) begin
          $display("%0t: product mismatch, expected %h, actual %h", $time, product_q[0],
                   m_axis_tdata);
          errors_o <= errors_o + 1;
          void'(product_q.pop_front());
        end else begin
          void'(product_q.pop_front());
        end
      end
    end
  end

endmodule

// ----- test/silu_gate_times_up_lut_tb.sv -----
// Testbench top for silu_gate_times_up_lut: drives table loads and gated products
// with random idling on both sides and reports the checker's verdict.
// Depends on silu_gate_times_up_lut and silu_gate_times_up_lut_checker.
module silu_gate_times_up_lut_tb;

  localparam logic OpProduct = 1'b0;
  localparam logic OpLoad    = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        calm = 1'b0;
  int          errors;
  int          pending;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  silu_gate_times_up_lut i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  silu_gate_times_up_lut_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 25);

  task automatic push_item(logic op, logic [15:0] g, logic [15:0] u, logic [6:0] idx,
                           logic [15:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, val, idx, u, g};
    do @(posedge clk_i); while (!s_axis_tready);
    if (!calm && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic push_product(logic [15:0] g, logic [15:0] u);
    push_item(OpProduct, g, u, 7'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] random_sample();
    return {1'($urandom), 5'($urandom_range(30)), 10'($urandom)};
  endfunction

  function automatic logic [15:0] random_gate();
    if ($urandom_range(9) < 8) return {1'($urandom), 8'($urandom_range(131, 110)), 7'($urandom)};
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] random_up();
    if ($urandom_range(9) < 8) return {1'($urandom), 8'($urandom_range(150, 100)), 7'($urandom)};
    return 16'($urandom);
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < 128; k++) push_item(OpLoad, 16'($urandom), 16'($urandom), 7'(k),
                                            random_sample());
    push_item(OpLoad, 16'hFFFF, 16'hFFFF, 7'd127, 16'hFFFF);
    push_item(OpLoad, 16'h0000, 16'h0000, 7'd0, 16'h0000);
    push_product(16'h7FC1, 16'h3F80);
    push_product(16'h0000, 16'h3F80);
    push_product(16'h8000, 16'hFF80);
    push_product(16'hC100, 16'h4000);
    push_product(16'hFF80, 16'h3F80);
    push_product(16'h3800, 16'h3F80);
    push_product(16'h0001, 16'h7F7F);
    push_product(16'h4100, 16'hC000);
    push_product(16'h7F80, 16'h3F80);
    push_product(16'h7F80, 16'h0000);
    push_product(16'h3F80, 16'h7FC0);
    push_product(16'h3F80, 16'hFFFF);
    push_product(16'hC0FF, 16'h7F7F);
    push_product(16'h40FF, 16'h0080);
    push_product(16'h3980, 16'h3F80);
    push_product(16'hFFFF, 16'hFFFF);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    for (int k = 0; k < 560; k++) begin
      calm = (k >= 300 && k < 400);
      if (k == 500) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
      end
      if ($urandom_range(19) == 0)
        push_item(OpLoad, 16'($urandom), 16'($urandom), 7'($urandom), random_sample());
      else
        push_product(random_gate(), random_up());
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (30) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
